// ----- hdl/cds_pkg.sv -----
`default_nettype none

package cds_pkg;

    localparam int unsigned TOGGLE_MS_DEFAULT = 300;
    localparam int unsigned SETTLE_MS_DEFAULT = 800;

    localparam int unsigned WARN_W = 16;
    localparam logic [WARN_W-1:0] YELLOW_WARN_RESET = 16'd2000;
    localparam logic [WARN_W-1:0] RED_WARN_RESET    = 16'd2000;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_YELLOW_WARN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_WARN    = 1'd1;

    localparam logic [1:0] MODE_ACTIVATE   = 2'd0;
    localparam logic [1:0] MODE_TICK       = 2'd1;
    localparam logic [1:0] MODE_DEACTIVATE = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_YELLOW,
        PH_WAIT,
        PH_RED,
        PH_SETTLE,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic yellow_on;
        logic red_on;
        logic servo_write;
        logic servo_open;
        logic ack_request;
        logic done_res;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/cds_core.sv -----
`default_nettype none

module cds_core #(
    parameter int unsigned TOGGLE_MS = cds_pkg::TOGGLE_MS_DEFAULT,
    parameter int unsigned SETTLE_MS = cds_pkg::SETTLE_MS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [1:0]                  mode,
    input  wire logic                        ack_level,
    input  wire logic [cds_pkg::WARN_W-1:0]  yellow_warn_ms,
    input  wire logic [cds_pkg::WARN_W-1:0]  red_warn_ms,
    output cds_pkg::result_t                 result
);

    localparam int unsigned TW = $clog2(TOGGLE_MS + 1);
    localparam int unsigned PW = cds_pkg::WARN_W;

    cds_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]   toggle_count_reg, toggle_count_next;
    logic [PW-1:0]   phase_count_reg, phase_count_next;
    logic            yellow_lit_reg, yellow_lit_next;
    logic            red_lit_reg, red_lit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= cds_pkg::PH_IDLE;
            toggle_count_reg <= '0;
            phase_count_reg  <= '0;
            yellow_lit_reg   <= 1'b0;
            red_lit_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            toggle_count_reg <= toggle_count_next;
            phase_count_reg  <= phase_count_next;
            yellow_lit_reg   <= yellow_lit_next;
            red_lit_reg      <= red_lit_next;
        end
    end

    always_comb
    begin
        logic [TW-1:0]   tick_t;
        logic [PW:0]     tick_p;
        logic            wrap;
        logic            blink_lit;
        logic            blink_new;
        logic [PW-1:0]   blink_limit;
        logic            blink_end;
        logic            settle_end;

        phase_next        = phase_reg;
        toggle_count_next = toggle_count_reg;
        phase_count_next  = phase_count_reg;
        yellow_lit_next   = yellow_lit_reg;
        red_lit_next      = red_lit_reg;
        result            = '0;

        // Shared blink step: one lit bit and one limit, picked by phase
        blink_lit   = (phase_reg == cds_pkg::PH_RED) ? red_lit_reg : yellow_lit_reg;
        blink_limit = (phase_reg == cds_pkg::PH_RED) ? red_warn_ms : yellow_warn_ms;
        tick_t      = toggle_count_reg + 1'b1;
        wrap        = (tick_t >= TW'(TOGGLE_MS));
        tick_p      = {1'b0, phase_count_reg} + 1'b1;
        if (tick_p[PW])
        begin
            tick_p = {1'b0, {PW{1'b1}}};
        end
        blink_end  = (tick_p >= {1'b0, blink_limit});
        settle_end = (tick_p >= (PW+1)'(SETTLE_MS));
        blink_new  = (wrap ? ~blink_lit : blink_lit) & ~blink_end;

        unique case (mode)
            cds_pkg::MODE_ACTIVATE:
            begin
                phase_next        = cds_pkg::PH_YELLOW;
                toggle_count_next = '0;
                phase_count_next  = '0;
                yellow_lit_next   = 1'b0;
                red_lit_next      = 1'b0;
            end
            cds_pkg::MODE_DEACTIVATE:
            begin
                phase_next        = cds_pkg::PH_IDLE;
                toggle_count_next = '0;
                phase_count_next  = '0;
                yellow_lit_next   = 1'b0;
                red_lit_next      = 1'b0;
            end
            cds_pkg::MODE_TICK:
            begin
                unique case (phase_reg)
                    cds_pkg::PH_YELLOW, cds_pkg::PH_RED:
                    begin
                        if (phase_reg == cds_pkg::PH_RED)
                        begin
                            red_lit_next = blink_new;
                        end
                        else
                        begin
                            yellow_lit_next = blink_new;
                        end
                        if (blink_end)
                        begin
                            toggle_count_next  = '0;
                            phase_count_next   = '0;
                            result.servo_write = 1'b1;
                            if (phase_reg == cds_pkg::PH_YELLOW)
                            begin
                                phase_next         = cds_pkg::PH_WAIT;
                                result.servo_open  = 1'b1;
                                result.ack_request = 1'b1;
                            end
                            else
                            begin
                                phase_next = cds_pkg::PH_SETTLE;
                            end
                        end
                        else
                        begin
                            toggle_count_next = wrap ? '0 : tick_t;
                            phase_count_next  = tick_p[PW-1:0];
                        end
                    end
                    cds_pkg::PH_WAIT:
                    begin
                        if (ack_level)
                        begin
                            phase_next        = cds_pkg::PH_RED;
                            red_lit_next      = 1'b0;
                            toggle_count_next = '0;
                            phase_count_next  = '0;
                        end
                    end
                    cds_pkg::PH_SETTLE:
                    begin
                        if (settle_end)
                        begin
                            phase_next        = cds_pkg::PH_DONE;
                            toggle_count_next = '0;
                            phase_count_next  = '0;
                        end
                        else
                        begin
                            phase_count_next = tick_p[PW-1:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        result.yellow_on = yellow_lit_next;
        result.red_on    = red_lit_next;
        result.done_res  = (phase_next == cds_pkg::PH_DONE);
    end

endmodule

`default_nettype wire

// ----- hdl/chamber_door_sequencer.sv -----
// Chamber door sequencer: warning lights and door servo for a chamber.
//
// Input channel (in_valid / in_stall) carries one item per event: activate,
// a one-millisecond tick with the user acknowledge level, or deactivate.
// Every input item yields exactly one result item on the output channel
// (out_valid / out_stall): LED states, a servo command strobe with its
// direction, the acknowledge request pulse and the done flag.
// Flow: an accepted item is registered in the input register, stepped
// through the sequencer into the result queue, and offered on the output
// from the queue head. Throughput is one item per cycle while the
// two-entry result queue is not full.
// When the receiver stalls, results collect in the queue; once it is full,
// in_stall rises and the input register holds its item.
// Reset (rst_n low, asynchronous) empties the pipeline, puts the sequence
// in idle with both LEDs off and loads 2000 ms into both blink times.
// The cfg_write port updates blink times; write only while no item is open.

`default_nettype none

module chamber_door_sequencer #(
    parameter int unsigned TOGGLE_MS = cds_pkg::TOGGLE_MS_DEFAULT,
    parameter int unsigned SETTLE_MS = cds_pkg::SETTLE_MS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      mode,
    input  wire logic                            ack_level,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 yellow_on,
    output logic                                 red_on,
    output logic                                 servo_write,
    output logic                                 servo_open,
    output logic                                 ack_request,
    output logic                                 done_res,
    input  wire logic                            cfg_write,
    input  wire logic [cds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cds_pkg::WARN_W-1:0]      cfg_data
);

    // Blink time registers
    logic [cds_pkg::WARN_W-1:0] yellow_warn_ms_reg;
    logic [cds_pkg::WARN_W-1:0] red_warn_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yellow_warn_ms_reg <= cds_pkg::YELLOW_WARN_RESET;
            red_warn_ms_reg    <= cds_pkg::RED_WARN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cds_pkg::REG_YELLOW_WARN: yellow_warn_ms_reg <= cfg_data;
                cds_pkg::REG_RED_WARN:    red_warn_ms_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    logic       in_valid_reg;
    logic [1:0] mode_reg;
    logic       ack_level_reg;
    logic       in_take;
    logic       step;

    // Result queue, two entries
    cds_pkg::result_t q_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             pop;
    cds_pkg::result_t step_result;

    // Advance the input item whenever the queue has a free entry
    assign step     = in_valid_reg && (count_reg != 2'd2);
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg      <= mode;
            ack_level_reg <= ack_level;
        end
    end

    cds_core #(
        .TOGGLE_MS (TOGGLE_MS),
        .SETTLE_MS (SETTLE_MS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .mode           (mode_reg),
        .ack_level      (ack_level_reg),
        .yellow_warn_ms (yellow_warn_ms_reg),
        .red_warn_ms    (red_warn_ms_reg),
        .result         (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (step)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, step} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            q_reg[wr_ptr_reg] <= step_result;
        end
    end

    // Drive the head entry
    assign out_valid   = (count_reg != 2'd0);
    assign yellow_on   = q_reg[rd_ptr_reg].yellow_on;
    assign red_on      = q_reg[rd_ptr_reg].red_on;
    assign servo_write = q_reg[rd_ptr_reg].servo_write;
    assign servo_open  = q_reg[rd_ptr_reg].servo_open;
    assign ack_request = q_reg[rd_ptr_reg].ack_request;
    assign done_res    = q_reg[rd_ptr_reg].done_res;

endmodule

`default_nettype wire

// ----- hdl/cds_checker.sv -----
`default_nettype none

module cds_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic yellow_on,
    input wire logic red_on,
    input wire logic servo_write,
    input wire logic servo_open,
    input wire logic ack_request,
    input wire logic done_res
);

    // Open command always comes with a servo strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && servo_open |-> servo_write)
        else $error("servo_open without servo_write");

    // Acknowledge request only on the door-open command
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ack_request |-> servo_write && servo_open)
        else $error("ack_request without open command");

    // Never both LEDs lit, and none once finished
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(yellow_on && red_on) && !(done_res && (yellow_on || red_on)))
        else $error("LED state inconsistent");

    // Stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind chamber_door_sequencer cds_checker u_cds_checker (.*);

`default_nettype wire
